>>> hdl/rmsprop_pkg.sv
// Shared types and constants for the RMSProp parameter update core.
package rmsprop_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [1:0] CFG_DECAY_RATE    = 2'd1;
    localparam logic [1:0] CFG_EPSILON       = 2'd2;
    localparam logic [1:0] CFG_RHO           = 2'd3;

    localparam logic [31:0] LR_RESET      = 32'd16777;
    localparam logic [31:0] DECAY_RESET   = 32'd0;
    localparam logic [31:0] EPSILON_RESET = 32'd1;
    localparam logic [16:0] RHO_RESET     = 17'd58982;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [33:0] DELTA_MAX = 34'h2_0000_0000;

    localparam int LR_STEPS = 32;   // quotient bits of the decayed learning rate
    localparam int SQ_STEPS = 25;   // root bits
    localparam int DV_STEPS = 34;   // quotient bits of the step size

    // per-word data that rides the whole pipeline
    typedef struct packed {
        logic        inrange;
        logic        gneg;
        logic [31:0] gmag;
        logic [31:0] value;
        logic        sat;
    } t_carry;

    // learning-rate divider and square root, one bit per stage
    typedef struct packed {
        t_carry      cy;
        logic [56:0] den;
        logic [56:0] rem;
        logic [31:0] nlo;
        logic [31:0] q;
        logic [49:0] rad;
        logic [27:0] srem;
        logic [24:0] root;
    } t_rt;

    // step-size divider, one bit per stage
    typedef struct packed {
        t_carry      cy;
        logic [24:0] r;
        logic        ovf;
        logic [24:0] rem;
        logic [33:0] nlo;
        logic [33:0] q;
    } t_dv;

endpackage

>>> hdl/rmsprop_parameter_update_core.sv
// RMSProp update core: per-element squared-gradient caches and the parameter step pipeline.
//
// Takes one word per cycle while o_stall is low and returns one result word per input,
// in order. The caches sit in two single-port-write RAMs that are read with the
// stage-2 address, so the data reaches stage 3, and written back from stage 3; a
// back-to-back hit on the same element is forwarded from the write-back register. The
// decayed learning rate (32 stages) and the square root (25 stages) run bit-serially in
// a shared pipeline, followed by a 34-stage divider for the step size. After reset a
// clearing pass over every cache address zeroes the caches and o_stall stays high;
// register writes are taken during that time. A two-entry output (register plus skid)
// lets the pipeline keep accepting while one result waits.
module rmsprop_parameter_update_core #(
    parameter int WEIGHT_COUNT = 1024,
    parameter int BIAS_COUNT   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [9:0]  i_element_index,
    input  logic signed [31:0] i_gradient,
    input  logic signed [31:0] i_current_value,
    input  logic [23:0] i_iteration,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_updated_value,
    output logic        o_saturated
);

    localparam int WAW  = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
    localparam int BAW  = (BIAS_COUNT > 1) ? $clog2(BIAS_COUNT) : 1;
    localparam int MAXC = (WEIGHT_COUNT > BIAS_COUNT) ? WEIGHT_COUNT : BIAS_COUNT;
    localparam int CW   = $clog2(MAXC + 1);
    localparam int LRS  = rmsprop_pkg::LR_STEPS;
    localparam int SQS  = rmsprop_pkg::SQ_STEPS;
    localparam int DVS  = rmsprop_pkg::DV_STEPS;

    // configuration
    logic [31:0] r_lr, r_decay, r_eps;
    logic [16:0] r_rho;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= rmsprop_pkg::LR_RESET;
            r_decay <= rmsprop_pkg::DECAY_RESET;
            r_eps   <= rmsprop_pkg::EPSILON_RESET;
            r_rho   <= rmsprop_pkg::RHO_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rmsprop_pkg::CFG_LEARNING_RATE: r_lr    <= i_cfg_data;
                rmsprop_pkg::CFG_DECAY_RATE:    r_decay <= i_cfg_data;
                rmsprop_pkg::CFG_EPSILON:       r_eps   <= i_cfg_data;
                rmsprop_pkg::CFG_RHO:           r_rho   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic [16:0] rho_eff, one_minus;
    assign rho_eff   = (r_rho > rmsprop_pkg::ONE_Q16) ? rmsprop_pkg::ONE_Q16 : r_rho;
    assign one_minus = rmsprop_pkg::ONE_Q16 - rho_eff;

    // clearing pass
    logic          r_clr_busy;
    logic [CW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == CW'(MAXC - 1)) r_clr_busy <= 1'b0;
        end
    end

    // handshake
    logic r_skid_v, r_out_v, advance, accept, out_ready;
    assign advance   = !r_skid_v;
    assign o_stall   = r_clr_busy || !advance;
    assign accept    = i_valid && !o_stall;
    assign out_ready = !r_out_v || !i_stall;

    // stage 1: capture
    logic                r_s1_v, r_s1_op;
    logic [9:0]          r_s1_idx;
    logic [23:0]         r_s1_iter;
    rmsprop_pkg::t_carry r_s1_cy, in_cy;

    always_comb begin
        in_cy.inrange = i_op ? (32'(i_element_index) < 32'(BIAS_COUNT))
                             : (32'(i_element_index) < 32'(WEIGHT_COUNT));
        in_cy.gneg    = i_gradient[31];
        in_cy.gmag    = i_gradient[31] ? (~i_gradient + 32'd1) : i_gradient;
        in_cy.value   = i_current_value;
        in_cy.sat     = 1'b0;
    end

    // stage 2: square and decay product
    logic                r_s2_v, r_s2_op;
    logic [9:0]          r_s2_idx;
    rmsprop_pkg::t_carry r_s2_cy;
    logic [47:0]         r_s2_g2;
    logic [55:0]         r_s2_dp;
    logic [63:0]         s1_sq;
    logic [55:0]         s1_dp;
    assign s1_sq = r_s1_cy.gmag * r_s1_cy.gmag;
    assign s1_dp = r_decay * r_s1_iter;

    // stage 3: cache read data available, new cache computed
    logic                r_s3_v, r_s3_op;
    logic [9:0]          r_s3_idx;
    rmsprop_pkg::t_carry r_s3_cy;
    logic [64:0]         r_s3_t;
    logic [56:0]         r_s3_den;
    logic [64:0]         s2_t;
    assign s2_t = one_minus * r_s2_g2;

    // stage 4: write-back register
    logic                r_s4_v, r_s4_op;
    logic [9:0]          r_s4_idx;
    rmsprop_pkg::t_carry r_s4_cy;
    logic [31:0]         r_s4_c;
    logic [56:0]         r_s4_den;

    logic [31:0]         r_wq, r_bq, cold, s3_c;
    logic [48:0]         s3_rc, s3_cfull;
    logic [64:0]         s3_sum;
    logic                s3_fwd, s3_csat;
    rmsprop_pkg::t_carry s3_cy;

    always_comb begin
        s3_fwd   = r_s4_v && r_s4_cy.inrange && (r_s4_op == r_s3_op) && (r_s4_idx == r_s3_idx);
        cold     = s3_fwd ? r_s4_c : (r_s3_op ? r_bq : r_wq);
        s3_rc    = rho_eff * cold;
        s3_sum   = 65'(s3_rc) + r_s3_t;
        s3_cfull = s3_sum[64:16];
        s3_csat  = |s3_cfull[48:32];
        s3_c     = s3_csat ? '1 : s3_cfull[31:0];
        s3_cy     = r_s3_cy;
        s3_cy.sat = s3_csat;
    end

    // cache memories
    logic [31:0] mem_w [WEIGHT_COUNT];
    logic [31:0] mem_b [BIAS_COUNT];

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (r_clr_cnt < CW'(WEIGHT_COUNT)) mem_w[r_clr_cnt[WAW-1:0]] <= '0;
        end else if (advance && r_s3_v && r_s3_cy.inrange && !r_s3_op) begin
            mem_w[WAW'(r_s3_idx)] <= s3_c;
        end
        if (advance) r_wq <= mem_w[WAW'(r_s2_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (r_clr_cnt < CW'(BIAS_COUNT)) mem_b[r_clr_cnt[BAW-1:0]] <= '0;
        end else if (advance && r_s3_v && r_s3_cy.inrange && r_s3_op) begin
            mem_b[BAW'(r_s3_idx)] <= s3_c;
        end
        if (advance) r_bq <= mem_b[BAW'(r_s2_idx)];
    end

    // learning-rate divider and root
    rmsprop_pkg::t_rt r_rt   [LRS];
    rmsprop_pkg::t_rt rt_src [LRS];
    rmsprop_pkg::t_rt rt_nx  [LRS];
    logic [LRS-1:0]   r_rt_v;
    logic [32:0]      s4_ce;

    assign s4_ce = 33'(r_s4_c) + 33'(r_eps);

    always_comb begin
        rt_src[0].cy   = r_s4_cy;
        rt_src[0].den  = r_s4_den;
        rt_src[0].rem  = 57'(r_lr[31:16]);
        rt_src[0].nlo  = {r_lr[15:0], 16'd0};
        rt_src[0].q    = '0;
        rt_src[0].rad  = 50'({s4_ce, 16'd0});
        rt_src[0].srem = '0;
        rt_src[0].root = '0;
        for (int j = 1; j < LRS; j++) rt_src[j] = r_rt[j-1];
    end

    always_comb begin
        logic [57:0] lt;
        logic [27:0] st;
        logic [27:0] trial;
        for (int j = 0; j < LRS; j++) begin
            rt_nx[j] = rt_src[j];
            lt = {rt_src[j].rem, rt_src[j].nlo[31]};
            if (lt >= {1'b0, rt_src[j].den}) begin
                rt_nx[j].rem = 57'(lt - {1'b0, rt_src[j].den});
                rt_nx[j].q   = {rt_src[j].q[30:0], 1'b1};
            end else begin
                rt_nx[j].rem = lt[56:0];
                rt_nx[j].q   = {rt_src[j].q[30:0], 1'b0};
            end
            rt_nx[j].nlo = {rt_src[j].nlo[30:0], 1'b0};
            if (j < SQS) begin
                st    = {rt_src[j].srem[25:0], rt_src[j].rad[49:48]};
                trial = {1'b0, rt_src[j].root, 2'b01};
                if (st >= trial) begin
                    rt_nx[j].srem = st - trial;
                    rt_nx[j].root = {rt_src[j].root[23:0], 1'b1};
                end else begin
                    rt_nx[j].srem = st;
                    rt_nx[j].root = {rt_src[j].root[23:0], 1'b0};
                end
                rt_nx[j].rad = {rt_src[j].rad[47:0], 2'b00};
            end
        end
    end

    // product of learning rate and gradient
    logic                r_m_v;
    rmsprop_pkg::t_carry r_m_cy;
    logic [63:0]         r_m_prod;
    logic [24:0]         r_m_r;
    logic [24:0]         rt_root;
    assign rt_root = r_rt[LRS-1].root;

    // step-size divider
    rmsprop_pkg::t_dv r_dv   [DVS];
    rmsprop_pkg::t_dv dv_src [DVS];
    rmsprop_pkg::t_dv dv_nx  [DVS];
    logic [DVS-1:0]   r_dv_v;
    logic [21:0]      m_high;

    assign m_high = r_m_prod[63:42];

    always_comb begin
        dv_src[0].cy  = r_m_cy;
        dv_src[0].r   = r_m_r;
        dv_src[0].ovf = 25'(m_high) >= r_m_r;
        dv_src[0].rem = 25'(m_high);
        dv_src[0].nlo = r_m_prod[41:8];
        dv_src[0].q   = '0;
        for (int j = 1; j < DVS; j++) dv_src[j] = r_dv[j-1];
    end

    always_comb begin
        logic [25:0] dt;
        for (int j = 0; j < DVS; j++) begin
            dv_nx[j] = dv_src[j];
            dt = {dv_src[j].rem, dv_src[j].nlo[33]};
            if (dt >= {1'b0, dv_src[j].r}) begin
                dv_nx[j].rem = 25'(dt - {1'b0, dv_src[j].r});
                dv_nx[j].q   = {dv_src[j].q[32:0], 1'b1};
            end else begin
                dv_nx[j].rem = dt[24:0];
                dv_nx[j].q   = {dv_src[j].q[32:0], 1'b0};
            end
            dv_nx[j].nlo = {dv_src[j].nlo[32:0], 1'b0};
        end
    end

    // final: apply step and clamp
    logic               r_f_v, r_f_sat;
    logic [31:0]        r_f_upd;
    rmsprop_pkg::t_dv   dv_last;
    logic [33:0]        f_delta;
    logic signed [35:0] f_vx, f_dx, f_res;
    logic [31:0]        n_f_upd;
    logic               n_f_sat;

    always_comb begin
        dv_last = r_dv[DVS-1];
        if (dv_last.ovf || dv_last.q > rmsprop_pkg::DELTA_MAX) f_delta = rmsprop_pkg::DELTA_MAX;
        else f_delta = dv_last.q;
        f_vx  = {{4{dv_last.cy.value[31]}}, dv_last.cy.value};
        f_dx  = {2'b00, f_delta};
        f_res = dv_last.cy.gneg ? (f_vx + f_dx) : (f_vx - f_dx);
        n_f_sat = dv_last.cy.sat;
        if (f_res > 36'sh0_7FFF_FFFF) begin
            n_f_upd = 32'h7FFF_FFFF;
            n_f_sat = 1'b1;
        end else if (f_res < -36'sh0_8000_0000) begin
            n_f_upd = 32'h8000_0000;
            n_f_sat = 1'b1;
        end else begin
            n_f_upd = f_res[31:0];
        end
        if (!dv_last.cy.inrange) begin
            n_f_upd = dv_last.cy.value;
            n_f_sat = 1'b0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_rt_v <= '0;
            r_m_v  <= 1'b0;
            r_dv_v <= '0;
            r_f_v  <= 1'b0;
        end else if (advance) begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_rt_v <= {r_rt_v[LRS-2:0], r_s4_v};
            r_m_v  <= r_rt_v[LRS-1];
            r_dv_v <= {r_dv_v[DVS-2:0], r_m_v};
            r_f_v  <= r_dv_v[DVS-1];
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_op   <= i_op;
            r_s1_idx  <= i_element_index;
            r_s1_iter <= i_iteration;
            r_s1_cy   <= in_cy;

            r_s2_op  <= r_s1_op;
            r_s2_idx <= r_s1_idx;
            r_s2_cy  <= r_s1_cy;
            r_s2_g2  <= s1_sq[63:16];
            r_s2_dp  <= s1_dp;

            r_s3_op  <= r_s2_op;
            r_s3_idx <= r_s2_idx;
            r_s3_cy  <= r_s2_cy;
            r_s3_t   <= s2_t;
            r_s3_den <= 57'(rmsprop_pkg::ONE_Q16) + 57'(r_s2_dp);

            r_s4_op     <= r_s3_op;
            r_s4_idx    <= r_s3_idx;
            r_s4_cy     <= s3_cy;
            r_s4_c      <= s3_c;
            r_s4_den    <= r_s3_den;

            for (int j = 0; j < LRS; j++) r_rt[j] <= rt_nx[j];

            r_m_cy   <= r_rt[LRS-1].cy;
            r_m_prod <= r_rt[LRS-1].q * r_rt[LRS-1].cy.gmag;
            r_m_r    <= (rt_root == '0) ? 25'd1 : rt_root;

            for (int j = 0; j < DVS; j++) r_dv[j] <= dv_nx[j];

            r_f_upd <= n_f_upd;
            r_f_sat <= n_f_sat;
        end
    end

    // output register and skid
    logic [31:0] r_out_upd, r_skid_upd;
    logic        r_out_sat, r_skid_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_f_v;
            end
        end else if (r_f_v && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            if (r_skid_v) begin
                r_out_upd <= r_skid_upd;
                r_out_sat <= r_skid_sat;
            end else begin
                r_out_upd <= r_f_upd;
                r_out_sat <= r_f_sat;
            end
        end else if (r_f_v && !r_skid_v) begin
            r_skid_upd <= r_f_upd;
            r_skid_sat <= r_f_sat;
        end
    end

    assign o_valid         = r_out_v;
    assign o_updated_value = r_out_upd;
    assign o_saturated     = r_out_sat;

    // checks
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held while output register empty");

    a_clear_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !(r_s1_v || r_s2_v || r_s3_v || r_s4_v))
        else $error("cache update in flight during clearing pass");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid loaded without an output stall");

endmodule
